/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl modules
// each macro expects signals named clock and reset in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBW_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SBW_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sbw_pkg.sv */
// ----------------------------------------------------------------------------
// sbw_pkg
// Shared types and constants of the seam blend weight block: field widths,
// register codes, label codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sbw_pkg;

   // default store geometry
   localparam int unsigned MAX_WIDTH_DEFAULT  = 2048;
   localparam int unsigned MAX_HEIGHT_DEFAULT = 1024;

   // port field widths
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 12;
   localparam int unsigned WIDTH_W     = 12;
   localparam int unsigned HEIGHT_W    = 11;
   localparam int unsigned STRIDE_W    = 8;
   localparam int unsigned MARGIN_W    = 9;
   localparam int unsigned POS_X_W     = 11;
   localparam int unsigned POS_Y_W     = 10;
   localparam int unsigned LABEL_W     = 2;
   localparam int unsigned WEIGHT_W    = 17;
   localparam int unsigned MIN_DIST_W  = 23;

   // register reset values
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd2048;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd1024;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd5;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 9'd409;

   // arithmetic constants
   localparam int unsigned SQRT2_Q16  = 92682;
   localparam int unsigned ROUND_HALF = 128;
   localparam int unsigned BEST_SCALE = 2560;
   localparam int unsigned DIV_STEPS  = 17;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'd65536;
   localparam logic [WEIGHT_W-1:0] WEIGHT_HALF = 17'd32768;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = 17'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_STRIDE = 2'd2,
      CSR_MARGIN = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [LABEL_W-1:0] {
      LABEL_NONE    = 2'd0,
      LABEL_RIGHT   = 2'd1,
      LABEL_LEFT    = 2'd2,
      LABEL_OVERLAP = 2'd3
   } label_type;

   // neighbor visited in one search step
   typedef enum logic [3:0] {
      PROBE_EAST      = 4'd0,
      PROBE_WEST      = 4'd1,
      PROBE_SOUTH     = 4'd2,
      PROBE_NORTH     = 4'd3,
      PROBE_SOUTHEAST = 4'd4,
      PROBE_NORTHWEST = 4'd5,
      PROBE_NORTHEAST = 4'd6,
      PROBE_SOUTHWEST = 4'd7,
      PROBE_END       = 4'd8
   } probe_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_CLASSIFY,
      ST_STEP,
      ST_MAP,
      ST_PROBE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic store;
      logic load;
      logic read_here;
      logic classify;
      logic step;
      logic map;
      logic probe;
      logic advance;
      logic div_start;
      logic div_step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic needs_search;
      logic more_steps;
      logic probes_done;
      logic div_last;
   } status_type;

endpackage

/* rtl/sbw_ram.sv */
// ----------------------------------------------------------------------------
// sbw_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module sbw_ram #(
   parameter int unsigned DATA_WIDTH = 2,
   parameter int unsigned DEPTH      = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sbw_ctrl.sv */
// ----------------------------------------------------------------------------
// sbw_ctrl
// Controller of the seam blend weight block: clearing pass, item intake,
// search sequencing, divider sequencing and the result handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sbw_pkg::cmd_type     cmd,
   input  sbw_pkg::status_type  status
);

   sbw_pkg::state_type state_ff;
   sbw_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbw_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sbw_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = sbw_pkg::ST_IDLE;
            end
         end
         sbw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_operation == sbw_pkg::OP_QUERY) begin
                  cmd.load = 1'b1;
                  state_in = sbw_pkg::ST_LOOKUP;
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         sbw_pkg::ST_LOOKUP: begin
            cmd.read_here = 1'b1;
            state_in      = sbw_pkg::ST_CLASSIFY;
         end
         sbw_pkg::ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            state_in     = status.needs_search ? sbw_pkg::ST_STEP : sbw_pkg::ST_DONE;
         end
         sbw_pkg::ST_STEP: begin
            if (status.more_steps) begin
               cmd.step = 1'b1;
               state_in = sbw_pkg::ST_MAP;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = sbw_pkg::ST_DIVIDE;
            end
         end
         sbw_pkg::ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = sbw_pkg::ST_PROBE;
         end
         sbw_pkg::ST_PROBE: begin
            cmd.probe = 1'b1;
            if (status.probes_done) begin
               cmd.advance = 1'b1;
               state_in    = sbw_pkg::ST_STEP;
            end
         end
         sbw_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = sbw_pkg::ST_DONE;
            end
         end
         sbw_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish = 1'b1;
               state_in    = sbw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbw_pkg::ST_IDLE;
         end
      endcase
   end

   // output beat valid: set on publish, dropped once taken
   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `SBW_ASSERT_IMP(a_publish_slot_free, cmd.publish, !rsp_valid_ff || !rsp_stall, "result overwritten while pending")
   `SBW_ASSERT_IMP(a_valid_from_publish, $rose(rsp_valid_ff), $past(cmd.publish), "result beat without publish")
   `SBW_ASSERT_NXT(a_query_starts_lookup, req_valid && !req_stall && req_operation == sbw_pkg::OP_QUERY, state_ff == sbw_pkg::ST_LOOKUP, "accepted query did not start")

endmodule

/* rtl/sbw_datapath.sv */
// ----------------------------------------------------------------------------
// sbw_datapath
// Datapath of the seam blend weight block: configuration registers, query
// context, per-step probe geometry, nearest distance tracking, a bit-serial
// divider for the weight and the result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbw_datapath #(
   parameter int unsigned MAX_WIDTH  = sbw_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_HEIGHT = sbw_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic [sbw_pkg::POS_X_W-1:0]                  req_pos_x,
   input  logic [sbw_pkg::POS_Y_W-1:0]                  req_pos_y,
   input  logic [sbw_pkg::LABEL_W-1:0]                  req_label,
   input  logic                                         csr_wr_en,
   input  logic [sbw_pkg::CSR_INDEX_W-1:0]              csr_index,
   input  logic [sbw_pkg::CSR_DATA_W-1:0]               csr_wdata,
   input  sbw_pkg::cmd_type                             cmd,
   output sbw_pkg::status_type                          status,
   output logic                                         ram_wr_en,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      ram_wr_addr,
   output logic [sbw_pkg::LABEL_W-1:0]                  ram_wr_data,
   output logic                                         ram_rd_en,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      ram_rd_addr,
   input  logic [sbw_pkg::LABEL_W-1:0]                  ram_rd_data,
   output logic [sbw_pkg::WEIGHT_W-1:0]                 rsp_weight,
   output logic [sbw_pkg::MIN_DIST_W-1:0]               rsp_min_distance
);

   localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned CW    = $clog2(MAX_WIDTH);
   localparam int unsigned XW    = $clog2(3 * MAX_WIDTH + 1);
   localparam int unsigned YW    = $clog2(MAX_HEIGHT + MAX_WIDTH / 2 + 1);
   localparam int unsigned IW    = $clog2(MAX_WIDTH / 2 + 256);
   localparam int unsigned DW    = $clog2(sbw_pkg::BEST_SCALE * MAX_WIDTH + 1);
   localparam int unsigned PW    = IW + 17;
   localparam int unsigned SW    = DW + 1;
   localparam int unsigned RMW   = DW + 2;
   localparam int unsigned NW    = DW + 17;
   localparam int unsigned QW    = sbw_pkg::WEIGHT_W;
   localparam int unsigned KW    = $clog2(sbw_pkg::DIV_STEPS);

   // configuration registers
   logic [sbw_pkg::WIDTH_W-1:0]  width_ff;
   logic [sbw_pkg::HEIGHT_W-1:0] height_ff;
   logic [sbw_pkg::STRIDE_W-1:0] stride_ff;
   logic [sbw_pkg::MARGIN_W-1:0] margin_ff;

   // clamped configuration
   logic [WW-1:0]                w_c;
   logic [HW-1:0]                h_c;
   logic [WW-1:0]                m_c;
   logic [sbw_pkg::STRIDE_W-1:0] s_c;

   // query context
   logic [sbw_pkg::POS_X_W-1:0]  x_ff;
   logic [sbw_pkg::POS_Y_W-1:0]  y_ff;
   logic [WW-1:0]                w_ff;
   logic [HW-1:0]                h_ff;
   logic [WW-1:0]                m_ff;
   logic [sbw_pkg::STRIDE_W-1:0] s_ff;
   logic [WW-1:0]                half_ff;
   logic [XW-1:0]                cols_ff;
   logic [XW-1:0]                cx_ff;
   logic                         outside_ff;
   logic                         search_ff;
   logic [QW-1:0]                plain_weight_ff;

   // clearing pass
   logic [AW-1:0] clr_ff;

   // step geometry
   logic [IW-1:0] i_ff;
   logic [XW-1:0] c_plus_ff;
   logic [XW-1:0] c_minus_ff;
   logic [YW-1:0] r_plus_ff;
   logic [YW-1:0] r_minus_ff;
   logic          xp_ff;
   logic          xm_ff;
   logic          yp_ff;
   logic          ym_ff;
   logic [DW-1:0] diag_ff;
   logic [CW-1:0] col_plus_ff;
   logic [CW-1:0] col_minus_ff;
   logic [CW-1:0] col_mid_ff;
   logic [AW-1:0] rb_plus_ff;
   logic [AW-1:0] rb_minus_ff;
   logic [AW-1:0] rb_mid_ff;
   logic [XW-1:0] c_plus_sum;
   logic [YW-1:0] r_plus_sum;
   logic [PW-1:0] diag_prod;

   // probe sequencing
   sbw_pkg::probe_type probe_idx_ff;
   logic               pend_valid_ff;
   logic               pend_diag_ff;
   logic               probe_cond;
   logic               probe_diag;
   logic [CW-1:0]      probe_col;
   logic [AW-1:0]      probe_base;
   logic               probe_issue;
   logic [DW-1:0]      pend_dist;

   // nearest distances
   logic [DW-1:0] best_l_ff;
   logic [DW-1:0] best_r_ff;
   logic [DW-1:0] best_min;

   // divider
   logic [SW-1:0]  sum_ff;
   logic [RMW-1:0] rem_ff;
   logic [16:0]    num_ff;
   logic [QW-1:0]  quo_ff;
   logic [KW-1:0]  div_cnt_ff;
   logic [SW-1:0]  sum_c;
   logic [NW-1:0]  num_c;
   logic [RMW-1:0] rem_shift;
   logic           rem_ge;
   logic [QW-1:0]  final_weight;

   // result registers
   logic [QW-1:0]                  rsp_weight_ff;
   logic [sbw_pkg::MIN_DIST_W-1:0] rsp_min_distance_ff;

   logic [AW-1:0] here_addr;
   logic [AW-1:0] store_addr;
   logic          store_ok;

   // extended column to image column
   function automatic logic [CW-1:0] map_col(input logic [XW-1:0] ec,
                                             input logic [XW-1:0] m,
                                             input logic [XW-1:0] w);
      logic [XW-1:0] col;
      if (ec < m) begin
         col = w - m + ec;
      end else if (ec < w + m) begin
         col = ec - m;
      end else begin
         col = ec - w - m;
      end
      return CW'(col);
   endfunction

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sbw_pkg::WIDTH_RESET;
         height_ff <= sbw_pkg::HEIGHT_RESET;
         stride_ff <= sbw_pkg::STRIDE_RESET;
         margin_ff <= sbw_pkg::MARGIN_RESET;
      end else if (csr_wr_en) begin
         unique case (sbw_pkg::csr_index_type'(csr_index))
            sbw_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[sbw_pkg::WIDTH_W-1:0];
            sbw_pkg::CSR_HEIGHT: height_ff <= csr_wdata[sbw_pkg::HEIGHT_W-1:0];
            sbw_pkg::CSR_STRIDE: stride_ff <= csr_wdata[sbw_pkg::STRIDE_W-1:0];
            sbw_pkg::CSR_MARGIN: margin_ff <= csr_wdata[sbw_pkg::MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp configuration to usable ranges
   always_comb begin
      if (width_ff == '0) begin
         w_c = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_c = WW'(MAX_WIDTH);
      end else begin
         w_c = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_c = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_c = HW'(MAX_HEIGHT);
      end else begin
         h_c = HW'(height_ff);
      end
      m_c = (32'(margin_ff) > 32'(w_c)) ? w_c : WW'(margin_ff);
      s_c = (stride_ff == '0) ? sbw_pkg::STRIDE_W'(1) : stride_ff;
   end

   // label writes and clearing pass
   assign store_ok   = (32'(req_pos_x) < 32'(MAX_WIDTH)) && (32'(req_pos_y) < 32'(MAX_HEIGHT));
   assign store_addr = AW'(req_pos_y) * AW'(MAX_WIDTH) + AW'(req_pos_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   always_comb begin
      if (cmd.clear_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = sbw_pkg::LABEL_NONE;
      end else begin
         ram_wr_en   = cmd.store && store_ok;
         ram_wr_addr = store_addr;
         ram_wr_data = req_label;
      end
   end

   // latch query context
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff       <= req_pos_x;
         y_ff       <= req_pos_y;
         w_ff       <= w_c;
         h_ff       <= h_c;
         m_ff       <= m_c;
         s_ff       <= s_c;
         half_ff    <= w_c >> 1;
         cols_ff    <= XW'(w_c) + XW'({m_c, 1'b0});
         cx_ff      <= XW'(req_pos_x) + XW'(m_c);
         outside_ff <= (32'(req_pos_x) >= 32'(w_c)) || (32'(req_pos_y) >= 32'(h_c));
      end
   end

   assign here_addr = AW'(y_ff) * AW'(MAX_WIDTH) + AW'(x_ff);

   // classify the query pixel
   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         search_ff <= status.needs_search;
         if (outside_ff) begin
            plain_weight_ff <= sbw_pkg::WEIGHT_HALF;
         end else begin
            unique case (sbw_pkg::label_type'(ram_rd_data))
               sbw_pkg::LABEL_LEFT:  plain_weight_ff <= sbw_pkg::WEIGHT_ZERO;
               sbw_pkg::LABEL_RIGHT: plain_weight_ff <= sbw_pkg::WEIGHT_ONE;
               sbw_pkg::LABEL_NONE:  plain_weight_ff <= sbw_pkg::WEIGHT_HALF;
               default:              plain_weight_ff <= sbw_pkg::WEIGHT_HALF;
            endcase
         end
      end
   end

   // step geometry: offsets, bounds and diagonal distance
   assign c_plus_sum = cx_ff + XW'(i_ff);
   assign r_plus_sum = YW'(y_ff) + YW'(i_ff);
   assign diag_prod  = PW'(i_ff) * PW'(sbw_pkg::SQRT2_Q16) + PW'(sbw_pkg::ROUND_HALF);

   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         i_ff <= '0;
      end else if (cmd.advance) begin
         i_ff <= i_ff + IW'(s_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         c_plus_ff  <= c_plus_sum;
         c_minus_ff <= cx_ff - XW'(i_ff);
         r_plus_ff  <= r_plus_sum;
         r_minus_ff <= YW'(y_ff) - YW'(i_ff);
         xp_ff      <= c_plus_sum < cols_ff;
         xm_ff      <= cx_ff > XW'(i_ff);
         yp_ff      <= r_plus_sum < YW'(h_ff);
         ym_ff      <= YW'(y_ff) > YW'(i_ff);
         diag_ff    <= DW'(diag_prod >> 8);
      end
   end

   // map extended columns and form row bases
   always_ff @(posedge clock) begin
      if (cmd.map) begin
         col_plus_ff  <= map_col(c_plus_ff, XW'(m_ff), XW'(w_ff));
         col_minus_ff <= map_col(c_minus_ff, XW'(m_ff), XW'(w_ff));
         col_mid_ff   <= CW'(x_ff);
         rb_plus_ff   <= AW'(r_plus_ff) * AW'(MAX_WIDTH);
         rb_minus_ff  <= AW'(r_minus_ff) * AW'(MAX_WIDTH);
         rb_mid_ff    <= AW'(y_ff) * AW'(MAX_WIDTH);
      end
   end

   // neighbor selection for the current probe
   always_comb begin
      probe_cond = 1'b0;
      probe_diag = 1'b0;
      probe_col  = col_mid_ff;
      probe_base = rb_mid_ff;
      unique case (probe_idx_ff)
         sbw_pkg::PROBE_EAST: begin
            probe_cond = xp_ff;
            probe_col  = col_plus_ff;
         end
         sbw_pkg::PROBE_WEST: begin
            probe_cond = xm_ff;
            probe_col  = col_minus_ff;
         end
         sbw_pkg::PROBE_SOUTH: begin
            probe_cond = yp_ff;
            probe_base = rb_plus_ff;
         end
         sbw_pkg::PROBE_NORTH: begin
            probe_cond = ym_ff;
            probe_base = rb_minus_ff;
         end
         sbw_pkg::PROBE_SOUTHEAST: begin
            probe_cond = xp_ff && yp_ff;
            probe_diag = 1'b1;
            probe_col  = col_plus_ff;
            probe_base = rb_plus_ff;
         end
         sbw_pkg::PROBE_NORTHWEST: begin
            probe_cond = xm_ff && ym_ff;
            probe_diag = 1'b1;
            probe_col  = col_minus_ff;
            probe_base = rb_minus_ff;
         end
         sbw_pkg::PROBE_NORTHEAST: begin
            probe_cond = xp_ff && ym_ff;
            probe_diag = 1'b1;
            probe_col  = col_plus_ff;
            probe_base = rb_minus_ff;
         end
         sbw_pkg::PROBE_SOUTHWEST: begin
            probe_cond = xm_ff && yp_ff;
            probe_diag = 1'b1;
            probe_col  = col_minus_ff;
            probe_base = rb_plus_ff;
         end
         sbw_pkg::PROBE_END: begin
            probe_cond = 1'b0;
         end
         default: begin
            probe_cond = 1'b0;
         end
      endcase
   end

   assign probe_issue = cmd.probe && (probe_idx_ff != sbw_pkg::PROBE_END);

   // probe counter and pending read tag
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_idx_ff  <= sbw_pkg::PROBE_END;
         pend_valid_ff <= 1'b0;
      end else begin
         if (cmd.map) begin
            probe_idx_ff <= sbw_pkg::PROBE_EAST;
         end else if (probe_issue) begin
            probe_idx_ff <= sbw_pkg::probe_type'(probe_idx_ff + 4'd1);
         end
         pend_valid_ff <= probe_issue && probe_cond;
      end
   end

   always_ff @(posedge clock) begin
      pend_diag_ff <= probe_diag;
   end

   // memory read port
   assign ram_rd_en   = cmd.read_here || probe_issue;
   assign ram_rd_addr = cmd.read_here ? here_addr : probe_base + AW'(probe_col);

   // nearest left-only and right-only distances
   assign pend_dist = pend_diag_ff ? diag_ff : DW'({i_ff, 8'h00});

   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         best_l_ff <= DW'(w_ff) * DW'(sbw_pkg::BEST_SCALE);
         best_r_ff <= DW'(w_ff) * DW'(sbw_pkg::BEST_SCALE);
      end else if (pend_valid_ff) begin
         if ((ram_rd_data == sbw_pkg::LABEL_LEFT) && (pend_dist < best_l_ff)) begin
            best_l_ff <= pend_dist;
         end
         if ((ram_rd_data == sbw_pkg::LABEL_RIGHT) && (pend_dist < best_r_ff)) begin
            best_r_ff <= pend_dist;
         end
      end
   end

   assign best_min = (best_l_ff < best_r_ff) ? best_l_ff : best_r_ff;

   // restoring divider, one quotient bit per cycle
   assign sum_c     = SW'(best_l_ff) + SW'(best_r_ff);
   assign num_c     = NW'({best_l_ff, 16'h0000}) + NW'(sum_c >> 1);
   assign rem_shift = {rem_ff[DW:0], num_ff[16]};
   assign rem_ge    = rem_shift >= RMW'(sum_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         sum_ff     <= sum_c;
         rem_ff     <= RMW'(num_c[NW-1:17]);
         num_ff     <= num_c[16:0];
         quo_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= rem_ge ? rem_shift - RMW'(sum_ff) : rem_shift;
         num_ff     <= {num_ff[15:0], 1'b0};
         quo_ff     <= {quo_ff[QW-2:0], rem_ge};
         div_cnt_ff <= div_cnt_ff + KW'(1);
      end
   end

   always_comb begin
      if (sum_ff == '0) begin
         final_weight = sbw_pkg::WEIGHT_HALF;
      end else if (quo_ff > sbw_pkg::WEIGHT_ONE) begin
         final_weight = sbw_pkg::WEIGHT_ONE;
      end else begin
         final_weight = quo_ff;
      end
   end

   // result registers, loaded only when the output slot is free
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_weight_ff       <= search_ff ? final_weight : plain_weight_ff;
         rsp_min_distance_ff <= search_ff ? sbw_pkg::MIN_DIST_W'(best_min) : '0;
      end
   end

   assign rsp_weight       = rsp_weight_ff;
   assign rsp_min_distance = rsp_min_distance_ff;

   // status to the controller
   always_comb begin
      status              = '0;
      status.clear_last   = clr_ff == AW'(DEPTH - 1);
      status.needs_search = !outside_ff && (ram_rd_data == sbw_pkg::LABEL_OVERLAP);
      status.more_steps   = i_ff < IW'(half_ff);
      status.probes_done  = probe_idx_ff == sbw_pkg::PROBE_END;
      status.div_last     = div_cnt_ff == KW'(sbw_pkg::DIV_STEPS - 1);
   end

   // checks
   `SBW_ASSERT_IMP(a_probe_read_free, probe_issue, !cmd.read_here && !cmd.classify, "probe collides with lookup")
   `SBW_ASSERT_NXT(a_pending_from_probe, cmd.map, !pend_valid_ff, "stale probe data after map")
   `SBW_ASSERT_IMP(a_div_count_range, cmd.div_step, div_cnt_ff < KW'(sbw_pkg::DIV_STEPS), "divider ran past its last step")

endmodule

/* rtl/seam_blend_weight.sv */
// ----------------------------------------------------------------------------
// seam_blend_weight
// Per-pixel coverage label store with seam blend weight queries. Label
// writes store a 2-bit coverage code; queries return the right image blend
// weight and, for overlap pixels, the nearest single-image distance found
// by an eight-direction strided search over the wrap-extended label map.
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   operation, pos_x, pos_y, label
//   rsp       out         rsp_valid/rsp_stall   weight, min_distance
//   csr       in          csr_wr_en             csr_index, csr_wdata
//
// After reset a clearing pass zeroes the label memory, one entry a cycle:
// with req_stall held high. Label writes are taken without leaving idle.
// A non-overlap query passes lookup and classify to its result register.
// An overlap query runs ceil((W/2)/stride) search steps, each forming its
// geometry and then reading the eight neighbors in turn through the single
// label memory read port, and the divider then forms the 17-bit weight.
// A pending result does not block intake; a finishing query waits for it.
// ----------------------------------------------------------------------------
module seam_blend_weight #(
   parameter int unsigned MAX_WIDTH  = sbw_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_HEIGHT = sbw_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [sbw_pkg::POS_X_W-1:0]       req_pos_x,
   input  logic [sbw_pkg::POS_Y_W-1:0]       req_pos_y,
   input  logic [sbw_pkg::LABEL_W-1:0]       req_label,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sbw_pkg::WEIGHT_W-1:0]      rsp_weight,
   output logic [sbw_pkg::MIN_DIST_W-1:0]    rsp_min_distance,
   input  logic                              csr_wr_en,
   input  logic [sbw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sbw_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AW    = $clog2(DEPTH);

   sbw_pkg::cmd_type            cmd;
   sbw_pkg::status_type         status;
   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [sbw_pkg::LABEL_W-1:0] ram_wr_data;
   logic                        ram_rd_en;
   logic [AW-1:0]               ram_rd_addr;
   logic [sbw_pkg::LABEL_W-1:0] ram_rd_data;

   // sequencing
   sbw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status)
   );

   // arithmetic and context
   sbw_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_label        (req_label),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .rsp_weight       (rsp_weight),
      .rsp_min_distance (rsp_min_distance)
   );

   // label memory
   sbw_ram #(
      .DATA_WIDTH (sbw_pkg::LABEL_W),
      .DEPTH      (DEPTH)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
